>>> src/arpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types and constants of the arp cache and responder
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int DEF_CACHE_ENTRIES = 256;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OP_REQUEST  = 16'h0001;
    localparam logic [15:0] OP_REPLY    = 16'h0002;

    // register select is paddr[3]: own_mac at 0x0, own_ip at 0x8
    localparam logic REG_OWN_MAC = 1'b0;
    localparam logic REG_OWN_IP  = 1'b1;

    localparam logic [1:0] OUT_IGNORED   = 2'd0;
    localparam logic [1:0] OUT_REFRESHED = 2'd1;
    localparam logic [1:0] OUT_INSERTED  = 2'd2;
    localparam logic [1:0] OUT_NO_CHANGE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } arpc_state_t;

    typedef struct packed {
        logic ip_en;
        logic mac_en;
    } arpc_wr_t;

endpackage

>>> src/arp_cache_and_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_and_responder
// checks one decoded arp header, searches and updates the ip-to-mac cache,
// and builds the reply fields for a request aimed at this interface
// ----------------------------------------------------------------------------
// channel   | handshake                        | payload
// header in | start, busy (beat: start & !busy)| hw_type .. target_ip
// result    | done, one cycle, no back-pressure| outcome, reply_*
// config    | apb, pready tied high            | own_mac @0x0, own_ip @0x8
//
// an ignored header gives its result in the cycle after the beat
// otherwise the cache is read one entry per cycle through the single ram read port:
// a search stops at the first hit, or on a miss after reading all fill entries,
// where fill is the number of valid entries, so at most CACHE_ENTRIES are read
// busy is low for an ignored header, high after the beat until the result
// cycle; reset clears the cache at once via the fill count, no clearing pass
// ----------------------------------------------------------------------------
module arp_cache_and_responder
    import arpc_pkg::*;
#(
    parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        start,
    output logic        busy,
    input  logic [15:0] hw_type,
    input  logic [15:0] proto_type,
    input  logic [7:0]  hw_len,
    input  logic [7:0]  proto_len,
    input  logic [15:0] opcode,
    input  logic [47:0] sender_mac,
    input  logic [31:0] sender_ip,
    input  logic [31:0] target_ip,

    output logic        done,
    output logic [1:0]  outcome,
    output logic        reply_valid,
    output logic [15:0] reply_hw_type,
    output logic [15:0] reply_proto_type,
    output logic [7:0]  reply_hw_len,
    output logic [7:0]  reply_proto_len,
    output logic [15:0] reply_opcode,
    output logic [47:0] reply_sender_mac,
    output logic [31:0] reply_sender_ip,
    output logic [47:0] reply_target_mac,
    output logic [31:0] reply_target_ip,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(CACHE_ENTRIES);
    localparam int CW = $clog2(CACHE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CACHE_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(CACHE_ENTRIES - 1);

    // configuration
    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3])
                REG_OWN_MAC: own_mac_reg <= pwdata[47:0];
                REG_OWN_IP:  own_ip_reg  <= pwdata[31:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            REG_OWN_MAC: prdata = {16'h0, own_mac_reg};
            REG_OWN_IP:  prdata = {32'h0, own_ip_reg};
            default:     prdata = '0;
        endcase
    end

    // sequencer state
    arpc_state_t   state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          cmp_pend_reg, cmp_pend_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          hit_reg, hit_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] ins_ptr_reg, ins_ptr_next;

    // captured header
    logic [7:0]  hw_len_reg, hw_len_next;
    logic [7:0]  proto_len_reg, proto_len_next;
    logic [15:0] opcode_reg, opcode_next;
    logic [47:0] sender_mac_reg, sender_mac_next;
    logic [31:0] sender_ip_reg, sender_ip_next;
    logic [31:0] target_ip_reg, target_ip_next;

    // result
    logic        done_reg, done_next;
    logic [1:0]  outcome_reg, outcome_next;
    logic        rvalid_reg, rvalid_next;
    logic [15:0] r_hw_type_reg, r_hw_type_next;
    logic [15:0] r_proto_type_reg, r_proto_type_next;
    logic [7:0]  r_hw_len_reg, r_hw_len_next;
    logic [7:0]  r_proto_len_reg, r_proto_len_next;
    logic [15:0] r_opcode_reg, r_opcode_next;
    logic [47:0] r_smac_reg, r_smac_next;
    logic [31:0] r_sip_reg, r_sip_next;
    logic [47:0] r_tmac_reg, r_tmac_next;
    logic [31:0] r_tip_reg, r_tip_next;

    // cache ram
    arpc_wr_t      mem_wr;
    logic [AW-1:0] mem_waddr;
    logic          mem_rd_en;
    logic [31:0]   mem_rd_ip;

    logic accept;
    logic hdr_ok;
    logic for_us;
    logic is_req;

    assign accept = start && (state_reg == ST_IDLE);
    assign hdr_ok = (hw_type == HW_ETHERNET) && (proto_type == PROTO_IPV4);
    assign for_us = (target_ip_reg == own_ip_reg);
    assign is_req = for_us && (opcode_reg == OP_REQUEST);

    arpc_cache_mem #(
        .ENTRIES (CACHE_ENTRIES),
        .AW      (AW)
    ) u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .waddr (mem_waddr),
        .wip   (sender_ip_reg),
        .wmac  (sender_mac_reg),
        .rd_en (mem_rd_en),
        .raddr (idx_reg[AW-1:0]),
        .rd_ip (mem_rd_ip)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            cmp_pend_reg <= 1'b0;
            hit_reg      <= 1'b0;
            fill_reg     <= '0;
            ins_ptr_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            cmp_pend_reg <= cmp_pend_next;
            hit_reg      <= hit_next;
            fill_reg     <= fill_next;
            ins_ptr_reg  <= ins_ptr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg      <= cmp_idx_next;
        hit_idx_reg      <= hit_idx_next;
        hw_len_reg       <= hw_len_next;
        proto_len_reg    <= proto_len_next;
        opcode_reg       <= opcode_next;
        sender_mac_reg   <= sender_mac_next;
        sender_ip_reg    <= sender_ip_next;
        target_ip_reg    <= target_ip_next;
        outcome_reg      <= outcome_next;
        rvalid_reg       <= rvalid_next;
        r_hw_type_reg    <= r_hw_type_next;
        r_proto_type_reg <= r_proto_type_next;
        r_hw_len_reg     <= r_hw_len_next;
        r_proto_len_reg  <= r_proto_len_next;
        r_opcode_reg     <= r_opcode_next;
        r_smac_reg       <= r_smac_next;
        r_sip_reg        <= r_sip_next;
        r_tmac_reg       <= r_tmac_next;
        r_tip_reg        <= r_tip_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        cmp_pend_next     = 1'b0;
        cmp_idx_next      = cmp_idx_reg;
        hit_next          = hit_reg;
        hit_idx_next      = hit_idx_reg;
        fill_next         = fill_reg;
        ins_ptr_next      = ins_ptr_reg;
        hw_len_next       = hw_len_reg;
        proto_len_next    = proto_len_reg;
        opcode_next       = opcode_reg;
        sender_mac_next   = sender_mac_reg;
        sender_ip_next    = sender_ip_reg;
        target_ip_next    = target_ip_reg;
        done_next         = 1'b0;
        outcome_next      = outcome_reg;
        rvalid_next       = rvalid_reg;
        r_hw_type_next    = r_hw_type_reg;
        r_proto_type_next = r_proto_type_reg;
        r_hw_len_next     = r_hw_len_reg;
        r_proto_len_next  = r_proto_len_reg;
        r_opcode_next     = r_opcode_reg;
        r_smac_next       = r_smac_reg;
        r_sip_next        = r_sip_reg;
        r_tmac_next       = r_tmac_reg;
        r_tip_next        = r_tip_reg;
        mem_wr            = '0;
        mem_waddr         = ins_ptr_reg;
        mem_rd_en         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hw_len_next     = hw_len;
                    proto_len_next  = proto_len;
                    opcode_next     = opcode;
                    sender_mac_next = sender_mac;
                    sender_ip_next  = sender_ip;
                    target_ip_next  = target_ip;
                    idx_next        = '0;
                    hit_next        = 1'b0;
                    if (hdr_ok)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        done_next         = 1'b1;
                        outcome_next      = OUT_IGNORED;
                        rvalid_next       = 1'b0;
                        r_hw_type_next    = '0;
                        r_proto_type_next = '0;
                        r_hw_len_next     = '0;
                        r_proto_len_next  = '0;
                        r_opcode_next     = '0;
                        r_smac_next       = '0;
                        r_sip_next        = '0;
                        r_tmac_next       = '0;
                        r_tip_next        = '0;
                    end
                end
            end

            ST_SEARCH:
            begin
                // ram read issued one cycle, compared the next
                if (cmp_pend_reg && (mem_rd_ip == sender_ip_reg))
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    state_next   = ST_UPDATE;
                end
                else if (idx_reg < fill_reg)
                begin
                    mem_rd_en     = 1'b1;
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = idx_reg[AW-1:0];
                    idx_next      = idx_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (hit_reg)
                begin
                    mem_wr.mac_en = 1'b1;
                    mem_waddr     = hit_idx_reg;
                    outcome_next  = OUT_REFRESHED;
                end
                else if (for_us)
                begin
                    mem_wr.ip_en  = 1'b1;
                    mem_wr.mac_en = 1'b1;
                    mem_waddr     = ins_ptr_reg;
                    ins_ptr_next  = (ins_ptr_reg == LAST_ADDR) ? '0
                                                               : ins_ptr_reg + AW'(1);
                    if (fill_reg != FULL_COUNT)
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    outcome_next = OUT_INSERTED;
                end
                else
                begin
                    outcome_next = OUT_NO_CHANGE;
                end

                rvalid_next       = is_req;
                r_hw_type_next    = is_req ? HW_ETHERNET : '0;
                r_proto_type_next = is_req ? PROTO_IPV4 : '0;
                r_hw_len_next     = is_req ? hw_len_reg : '0;
                r_proto_len_next  = is_req ? proto_len_reg : '0;
                r_opcode_next     = is_req ? OP_REPLY : '0;
                r_smac_next       = is_req ? own_mac_reg : '0;
                r_sip_next        = is_req ? target_ip_reg : '0;
                r_tmac_next       = is_req ? sender_mac_reg : '0;
                r_tip_next        = is_req ? sender_ip_reg : '0;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign outcome          = outcome_reg;
    assign reply_valid      = rvalid_reg;
    assign reply_hw_type    = r_hw_type_reg;
    assign reply_proto_type = r_proto_type_reg;
    assign reply_hw_len     = r_hw_len_reg;
    assign reply_proto_len  = r_proto_len_reg;
    assign reply_opcode     = r_opcode_reg;
    assign reply_sender_mac = r_smac_reg;
    assign reply_sender_ip  = r_sip_reg;
    assign reply_target_mac = r_tmac_reg;
    assign reply_target_ip  = r_tip_reg;

    // checks

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_COUNT)
        else $error("fill count beyond cache size");

    a_no_result_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> !done_reg)
        else $error("result strobe during search");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (idx_reg <= fill_reg))
        else $error("search index past valid entries");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && !hit_reg && for_us && fill_reg != FULL_COUNT)
            |=> (fill_reg == $past(fill_reg) + CW'(1)))
        else $error("insert did not grow the cache");

    a_reply_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && reply_valid) |-> (outcome_reg != OUT_IGNORED))
        else $error("reply for an ignored header");

endmodule

>>> src/arpc_cache_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_cache_mem
// ip and mac arrays of the cache, one write port, registered ip read
// ----------------------------------------------------------------------------
module arpc_cache_mem
    import arpc_pkg::*;
#(
    parameter int ENTRIES = DEF_CACHE_ENTRIES,
    parameter int AW      = $clog2(DEF_CACHE_ENTRIES)
)
(
    input  logic          clk,
    input  arpc_wr_t      wr,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wip,
    input  logic [47:0]   wmac,
    input  logic          rd_en,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rd_ip
);

    logic [31:0] ip_mem [ENTRIES];
    logic [47:0] mac_mem [ENTRIES];
    logic [31:0] rd_ip_reg;

    always_ff @(posedge clk)
    begin
        if (wr.ip_en)
        begin
            ip_mem[waddr] <= wip;
        end
        if (rd_en)
        begin
            rd_ip_reg <= ip_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.mac_en)
        begin
            mac_mem[waddr] <= wmac;
        end
    end

    assign rd_ip = rd_ip_reg;

endmodule

>>> verif/tb_arp_cache_and_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arp_cache_and_responder
// drives decoded arp headers into the cache and responder, mirrors the cache
// contents and round-robin insertion, and checks every result field against
// the mirror's prediction; own_mac and own_ip are changed between phases
// ----------------------------------------------------------------------------
module tb_arp_cache_and_responder;
    import arpc_pkg::*;

    localparam int CACHE_N      = DEF_CACHE_ENTRIES;
    localparam int CLK_PERIOD   = 12;
    localparam int LIMIT_CYCLES = 1_500_000;

    typedef struct packed {
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
    } arp_hdr_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic        valid;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [47:0] target_mac;
        logic [31:0] target_ip;
    } arp_result_t;

    class arp_cache_mirror;
        logic [47:0] own_mac;
        logic [31:0] own_ip;
        logic [31:0] entry_ip [CACHE_N];
        logic [47:0] entry_mac [CACHE_N];
        bit          entry_valid [CACHE_N];
        int unsigned insert_ptr;
        int unsigned fill_count;
        int unsigned insert_total;
        int unsigned error_count;
        arp_result_t pending_replies[$];

        function new();
            own_mac      = '0;
            own_ip       = '0;
            insert_ptr   = 0;
            fill_count   = 0;
            insert_total = 0;
            error_count  = 0;
            foreach (entry_valid[i])
                entry_valid[i] = 1'b0;
        endfunction

        function void note_header(arp_hdr_t h);
            arp_result_t r;
            int          hit;
            int          i;
            bit          for_us;
            r = '0;
            if (h.hw_type == HW_ETHERNET && h.proto_type == PROTO_IPV4)
            begin
                // lookup walks the valid prefix only
                hit = -1;
                i   = 0;
                while (i < CACHE_N && entry_valid[i] && hit < 0)
                begin
                    if (entry_ip[i] == h.sender_ip)
                        hit = i;
                    i++;
                end
                for_us = (h.target_ip == own_ip);
                if (hit >= 0)
                begin
                    entry_mac[hit] = h.sender_mac;
                    r.outcome = OUT_REFRESHED;
                end
                else if (for_us)
                begin
                    entry_ip[insert_ptr]  = h.sender_ip;
                    entry_mac[insert_ptr] = h.sender_mac;
                    if (!entry_valid[insert_ptr])
                        fill_count++;
                    entry_valid[insert_ptr] = 1'b1;
                    insert_ptr = (insert_ptr + 1) % CACHE_N;
                    insert_total++;
                    r.outcome = OUT_INSERTED;
                end
                else
                begin
                    r.outcome = OUT_NO_CHANGE;
                end
                if (for_us && h.opcode == OP_REQUEST)
                begin
                    r.valid      = 1'b1;
                    r.hw_type    = h.hw_type;
                    r.proto_type = h.proto_type;
                    r.hw_len     = h.hw_len;
                    r.proto_len  = h.proto_len;
                    r.opcode     = OP_REPLY;
                    r.sender_mac = own_mac;
                    r.sender_ip  = h.target_ip;
                    r.target_mac = h.sender_mac;
                    r.target_ip  = h.sender_ip;
                end
            end
            else
            begin
                r.outcome = OUT_IGNORED;
            end
            pending_replies.push_back(r);
        endfunction

        function void report_field(string name, logic [63:0] want, logic [63:0] seen);
            if (seen !== want)
            begin
                error_count++;
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $time, name, want, seen);
            end
        endfunction

        function void check_reply(arp_result_t got);
            arp_result_t want;
            if (pending_replies.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, got outcome %0d",
                         $time, got.outcome);
                return;
            end
            want = pending_replies.pop_front();
            report_field("outcome", want.outcome, got.outcome);
            report_field("reply_valid", want.valid, got.valid);
            report_field("reply_hw_type", want.hw_type, got.hw_type);
            report_field("reply_proto_type", want.proto_type, got.proto_type);
            report_field("reply_hw_len", want.hw_len, got.hw_len);
            report_field("reply_proto_len", want.proto_len, got.proto_len);
            report_field("reply_opcode", want.opcode, got.opcode);
            report_field("reply_sender_mac", want.sender_mac, got.sender_mac);
            report_field("reply_sender_ip", want.sender_ip, got.sender_ip);
            report_field("reply_target_mac", want.target_mac, got.target_mac);
            report_field("reply_target_ip", want.target_ip, got.target_ip);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] hw_type = '0;
    logic [15:0] proto_type = '0;
    logic [7:0]  hw_len = '0;
    logic [7:0]  proto_len = '0;
    logic [15:0] opcode = '0;
    logic [47:0] sender_mac = '0;
    logic [31:0] sender_ip = '0;
    logic [31:0] target_ip = '0;
    logic        done;
    logic [1:0]  outcome;
    logic        reply_valid;
    logic [15:0] reply_hw_type;
    logic [15:0] reply_proto_type;
    logic [7:0]  reply_hw_len;
    logic [7:0]  reply_proto_len;
    logic [15:0] reply_opcode;
    logic [47:0] reply_sender_mac;
    logic [31:0] reply_sender_ip;
    logic [47:0] reply_target_mac;
    logic [31:0] reply_target_ip;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    arp_cache_mirror mirror = new();
    bit              steady = 1'b0;

    arp_cache_and_responder #(
        .CACHE_ENTRIES(CACHE_N)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .hw_type          (hw_type),
        .proto_type       (proto_type),
        .hw_len           (hw_len),
        .proto_len        (proto_len),
        .opcode           (opcode),
        .sender_mac       (sender_mac),
        .sender_ip        (sender_ip),
        .target_ip        (target_ip),
        .done             (done),
        .outcome          (outcome),
        .reply_valid      (reply_valid),
        .reply_hw_type    (reply_hw_type),
        .reply_proto_type (reply_proto_type),
        .reply_hw_len     (reply_hw_len),
        .reply_proto_len  (reply_proto_len),
        .reply_opcode     (reply_opcode),
        .reply_sender_mac (reply_sender_mac),
        .reply_sender_ip  (reply_sender_ip),
        .reply_target_mac (reply_target_mac),
        .reply_target_ip  (reply_target_ip),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // results are sampled at the edge that ends the done cycle
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            mirror.check_reply({outcome, reply_valid, reply_hw_type, reply_proto_type,
                                reply_hw_len, reply_proto_len, reply_opcode,
                                reply_sender_mac, reply_sender_ip, reply_target_mac,
                                reply_target_ip});
    end

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic arp_hdr_t mk_header(logic [15:0] hw, logic [15:0] proto,
                                           logic [7:0] hl, logic [7:0] pl,
                                           logic [15:0] op, logic [47:0] smac,
                                           logic [31:0] sip, logic [31:0] tip);
        arp_hdr_t h;
        h.hw_type    = hw;
        h.proto_type = proto;
        h.hw_len     = hl;
        h.proto_len  = pl;
        h.opcode     = op;
        h.sender_mac = smac;
        h.sender_ip  = sip;
        h.target_ip  = tip;
        return h;
    endfunction

    function automatic arp_hdr_t rand_header(int fresh_pct, int for_us_pct);
        arp_hdr_t h;
        int       pick;
        h.sender_mac = rand_mac();
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            // malformed header, sometimes only the protocol type is wrong
            h.hw_type    = $urandom_range(0, 1) ? HW_ETHERNET : 16'($urandom);
            h.proto_type = 16'($urandom);
        end
        else
        begin
            h.hw_type    = HW_ETHERNET;
            h.proto_type = PROTO_IPV4;
        end
        if ($urandom_range(0, 1))
        begin
            h.hw_len    = 8'd6;
            h.proto_len = 8'd4;
        end
        else
        begin
            h.hw_len    = 8'($urandom);
            h.proto_len = 8'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 70)
            h.opcode = OP_REQUEST;
        else if (pick < 88)
            h.opcode = OP_REPLY;
        else
            h.opcode = 16'($urandom);
        if (mirror.fill_count > 0 && $urandom_range(0, 99) >= fresh_pct)
            h.sender_ip = mirror.entry_ip[$urandom_range(0, mirror.fill_count - 1)];
        else
            h.sender_ip = $urandom;
        if ($urandom_range(0, 99) < for_us_pct)
            h.target_ip = mirror.own_ip;
        else
            h.target_ip = $urandom;
        return h;
    endfunction

    // called at a rising edge; returns at the edge that takes the beat, or once busy is low again
    task automatic send_header(arp_hdr_t h);
        int gap;
        if ($urandom_range(0, 99) < 5)
            steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        hw_type    <= h.hw_type;
        proto_type <= h.proto_type;
        hw_len     <= h.hw_len;
        proto_len  <= h.proto_len;
        opcode     <= h.opcode;
        sender_mac <= h.sender_mac;
        sender_ip  <= h.sender_ip;
        target_ip  <= h.target_ip;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        mirror.note_header(h);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (mirror.pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic reg_sel, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_OWN_MAC)
            mirror.own_mac = value[47:0];
        else
            mirror.own_ip = value[31:0];
        // idle the bus so a following write starts on a fresh edge
        @(posedge clk);
    endtask

    // counts only well-formed headers; keeps going until enough insertions
    task automatic run_phase(int count, int fresh_pct, int for_us_pct, int min_inserts);
        arp_hdr_t h;
        int       taken;
        taken = 0;
        while (taken < count || mirror.insert_total < min_inserts)
        begin
            h = rand_header(fresh_pct, for_us_pct);
            send_header(h);
            if (h.hw_type == HW_ETHERNET && h.proto_type == PROTO_IPV4)
                taken++;
        end
    endtask

    initial
    begin
        logic [31:0] ip_a;
        logic [47:0] mac_x;
        ip_a  = 32'hC0A8_0001;
        mac_x = rand_mac();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_reg(REG_OWN_MAC, {16'($urandom), 48'h0250_5A10_2030});
        write_reg(REG_OWN_IP, {32'($urandom), ip_a});

        // malformed headers, including the ipv6 protocol type
        send_header(mk_header(16'h0000, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST, mac_x,
                              32'h0A00_0001, ip_a));
        send_header(mk_header(16'hFFFF, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST, mac_x,
                              32'h0A00_0001, ip_a));
        send_header(mk_header(HW_ETHERNET, 16'h86DD, 8'd6, 8'd4, OP_REQUEST, mac_x,
                              32'h0A00_0001, ip_a));
        send_header(mk_header(HW_ETHERNET, 16'h0000, 8'd6, 8'd4, OP_REQUEST, mac_x,
                              32'h0A00_0001, ip_a));
        send_header(mk_header(HW_ETHERNET, 16'hFFFF, 8'd6, 8'd4, OP_REQUEST, mac_x,
                              32'h0A00_0001, ip_a));
        // request for us from a new sender, then the same sender again
        send_header(mk_header(HW_ETHERNET, PROTO_IPV4, 8'h00, 8'h00, OP_REQUEST,
                              48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, ip_a));
        send_header(mk_header(HW_ETHERNET, PROTO_IPV4, 8'hFF, 8'hFF, OP_REQUEST,
                              48'h0, 32'hFFFF_FFFF, ip_a));
        // reply for us inserts without answering
        send_header(mk_header(HW_ETHERNET, PROTO_IPV4, 8'd6, 8'd4, OP_REPLY,
                              rand_mac(), 32'h0000_0000, ip_a));
        // not for us: known sender is refreshed, unknown one leaves the cache alone
        send_header(mk_header(HW_ETHERNET, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST,
                              rand_mac(), 32'h0000_0000, 32'h0000_0000));
        send_header(mk_header(HW_ETHERNET, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST,
                              rand_mac(), 32'h0A0A_0A0A, 32'h0A00_0063));
        // odd opcodes handle the cache but never answer; then a request for us and one not
        send_header(mk_header(HW_ETHERNET, PROTO_IPV4, 8'd6, 8'd4, 16'h0000,
                              rand_mac(), 32'h0A0A_0A0B, ip_a));
        send_header(mk_header(HW_ETHERNET, PROTO_IPV4, 8'd6, 8'd4, 16'hFFFF,
                              rand_mac(), 32'h0A0A_0A0B, ip_a));
        send_header(mk_header(HW_ETHERNET, PROTO_IPV4, 8'd6, 8'd4, 16'h0003,
                              rand_mac(), 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_header(mk_header(HW_ETHERNET, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST,
                              rand_mac(), 32'h0A0A_0A0B, ip_a));
        send_header(mk_header(HW_ETHERNET, PROTO_IPV4, 8'd6, 8'd4, OP_REQUEST,
                              rand_mac(), 32'h0A0A_0A0C, ~ip_a));
        wait_drain();

        // mostly new senders aimed at us, enough to wrap the insertion pointer
        write_reg(REG_OWN_MAC, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_OWN_IP, 64'hFFFF_FFFF_FFFF_FFFF);
        run_phase(200, 95, 97, CACHE_N + 24);
        wait_drain();

        write_reg(REG_OWN_MAC, 64'h0);
        write_reg(REG_OWN_IP, 64'h0);
        run_phase(70, 30, 60, 0);
        wait_drain();

        write_reg(REG_OWN_MAC, {16'($urandom), rand_mac()});
        write_reg(REG_OWN_IP, {32'($urandom), 32'($urandom)});
        run_phase(60, 50, 80, 0);
        wait_drain();

        repeat (CACHE_N + 40) @(posedge clk);
        if (mirror.error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Verification failed");
        $finish;
    end

endmodule
